/* design/brb_pkg.sv */
// Shared types, constants and helpers of the circular byte FIFO.
package brb_pkg;

  localparam int unsigned CAPACITY  = 1024;
  localparam int unsigned MAX_BURST = 64;

  localparam int unsigned ADDR_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W  = 11;
  localparam int unsigned REQ_W  = 7;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned BYTE_W = 8;

  localparam logic [CNT_W-1:0]  CAP_CNT   = CNT_W'(CAPACITY);
  localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(CAPACITY - 1);
  localparam logic [REQ_W-1:0]  BURST_MAX = REQ_W'(MAX_BURST);

  // Item kinds as they arrive on the input channel.
  localparam logic [KIND_W-1:0] KIND_CODE_WRITE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CODE_READ  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CODE_PEEK  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CODE_SKIP  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CODE_FLUSH = 3'd4;

  typedef enum logic [2:0] {
    OP_WRITE = 3'd0,
    OP_READ  = 3'd1,
    OP_PEEK  = 3'd2,
    OP_SKIP  = 3'd3,
    OP_FLUSH = 3'd4,
    OP_NONE  = 3'd5
  } op_e;

  // Decoded command handed from the front to the back.
  typedef struct packed {
    op_e               op;
    logic [BYTE_W-1:0] data;
    logic [REQ_W-1:0]  req;    // already limited to one burst
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              byte_valid;
    logic              last;
    logic              accepted;
    logic [CNT_W-1:0]  fill;
    logic              highwater;
  } res_t;

  function automatic logic [ADDR_W-1:0] next_slot(input logic [ADDR_W-1:0] idx);
    next_slot = (idx == LAST_SLOT) ? '0 : idx + ADDR_W'(1);
  endfunction

endpackage

/* design/brb_front.sv */
// Front end: takes input items, decodes the kind, limits the request, queues commands.
module brb_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [brb_pkg::KIND_W-1:0]  kind_i,
  input  logic [brb_pkg::BYTE_W-1:0]  data_i,
  input  logic [brb_pkg::REQ_W-1:0]   req_i,
  output logic                        cmd_valid_o,
  output brb_pkg::cmd_t               cmd_o,
  input  logic                        cmd_pop_i
);

  brb_pkg::cmd_t cmd_in;
  brb_pkg::cmd_t slot_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    used_q;
  logic          push;

  always_comb begin
    cmd_in.data = data_i;
    cmd_in.req  = (req_i > brb_pkg::BURST_MAX) ? brb_pkg::BURST_MAX : req_i;
    unique case (kind_i)
      brb_pkg::KIND_CODE_WRITE: cmd_in.op = brb_pkg::OP_WRITE;
      brb_pkg::KIND_CODE_READ:  cmd_in.op = brb_pkg::OP_READ;
      brb_pkg::KIND_CODE_PEEK:  cmd_in.op = brb_pkg::OP_PEEK;
      brb_pkg::KIND_CODE_SKIP:  cmd_in.op = brb_pkg::OP_SKIP;
      brb_pkg::KIND_CODE_FLUSH: cmd_in.op = brb_pkg::OP_FLUSH;
      default:                  cmd_in.op = brb_pkg::OP_NONE;
    endcase
  end

  assign in_ready_o  = (used_q != 2'd2);
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (used_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      used_q   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (cmd_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      used_q <= used_q + 2'(push) - 2'(cmd_pop_i);
    end
  end

`ifndef ASSERT_OFF
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_i |-> cmd_valid_o)
    else $error("command popped from empty queue");
  a_used_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q != 2'd3)
    else $error("command queue overfilled");
  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q))
    else $error("queue pointers disagree with occupancy");
`endif

endmodule

/* design/brb_back.sv */
// Back end: byte store, pointers, fill level, high-water flag and result register.
module brb_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  input  brb_pkg::cmd_t              cmd_i,
  output logic                       cmd_pop_o,
  input  logic [brb_pkg::CNT_W-1:0]  mark_i,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output brb_pkg::res_t              res_o
);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_STREAM = 2'b10
  } state_e;

  state_e                       state_q, state_d;
  logic [brb_pkg::ADDR_W-1:0]   head_q, head_d, tail_q, tail_d, pos_q, pos_d;
  logic [brb_pkg::CNT_W-1:0]    count_q, count_d;
  logic                         hw_q, hw_d;
  logic [brb_pkg::REQ_W-1:0]    remain_q, remain_d;
  logic                         is_read_q, is_read_d;
  logic                         out_valid_q, out_valid_d;
  brb_pkg::res_t                out_q, res_d;
  logic                         load;
  logic                         out_free;

  logic [brb_pkg::BYTE_W-1:0]   mem_q [brb_pkg::CAPACITY];
  logic [brb_pkg::BYTE_W-1:0]   rd_data_q;
  logic [brb_pkg::ADDR_W-1:0]   rd_addr;
  logic                         mem_we;

  logic [brb_pkg::REQ_W-1:0]    n_move;
  logic [brb_pkg::ADDR_W:0]     skip_sum;
  logic [brb_pkg::ADDR_W-1:0]   pos_next;
  logic                         is_burst;

  assign out_free = !out_valid_q || res_ready_i;
  assign pos_next = brb_pkg::next_slot(pos_q);

  always_comb begin
    if (brb_pkg::CNT_W'(cmd_i.req) < count_q) begin
      n_move = cmd_i.req;
    end else begin
      n_move = count_q[brb_pkg::REQ_W-1:0];
    end
    skip_sum = {1'b0, tail_q} + (brb_pkg::ADDR_W+1)'(n_move);
    if (skip_sum >= (brb_pkg::ADDR_W+1)'(brb_pkg::CAPACITY)) begin
      skip_sum = skip_sum - (brb_pkg::ADDR_W+1)'(brb_pkg::CAPACITY);
    end
    is_burst = ((cmd_i.op == brb_pkg::OP_READ) || (cmd_i.op == brb_pkg::OP_PEEK))
               && (n_move != '0);
  end

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    tail_d    = tail_q;
    pos_d     = pos_q;
    count_d   = count_q;
    hw_d      = hw_q;
    remain_d  = remain_q;
    is_read_d = is_read_q;
    cmd_pop_o = 1'b0;
    load      = 1'b0;
    mem_we    = 1'b0;
    rd_addr   = tail_q;
    res_d     = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && is_burst) begin
          // start of a read or peek run; the first byte is fetched now
          cmd_pop_o = 1'b1;
          remain_d  = n_move;
          pos_d     = tail_q;
          is_read_d = (cmd_i.op == brb_pkg::OP_READ);
          state_d   = ST_STREAM;
        end else if (cmd_valid_i && out_free) begin
          cmd_pop_o = 1'b1;
          load      = 1'b1;
          case (cmd_i.op)
            brb_pkg::OP_WRITE: begin
              if (count_q < brb_pkg::CAP_CNT) begin
                mem_we         = 1'b1;
                head_d         = brb_pkg::next_slot(head_q);
                count_d        = count_q + brb_pkg::CNT_W'(1);
                res_d.accepted = 1'b1;
              end
              if ((mark_i != '0) && (count_d >= mark_i)) begin
                hw_d = 1'b1;
              end
            end
            brb_pkg::OP_READ: begin
              if ((mark_i != '0) && (count_q < mark_i)) begin
                hw_d = 1'b0;
              end
            end
            brb_pkg::OP_SKIP: begin
              tail_d  = skip_sum[brb_pkg::ADDR_W-1:0];
              count_d = count_q - brb_pkg::CNT_W'(n_move);
              if ((mark_i != '0) && (count_d < mark_i)) begin
                hw_d = 1'b0;
              end
            end
            brb_pkg::OP_FLUSH: begin
              head_d  = '0;
              tail_d  = '0;
              count_d = '0;
              hw_d    = 1'b0;
            end
            default: begin
            end
          endcase
          res_d.last      = 1'b1;
          res_d.fill      = count_d;
          res_d.highwater = hw_d;
        end
      end
      ST_STREAM: begin
        rd_addr = pos_q;
        if (out_free) begin
          load             = 1'b1;
          rd_addr          = pos_next;
          pos_d            = pos_next;
          remain_d         = remain_q - brb_pkg::REQ_W'(1);
          res_d.data       = rd_data_q;
          res_d.byte_valid = 1'b1;
          res_d.last       = (remain_q == brb_pkg::REQ_W'(1));
          if (is_read_q) begin
            tail_d  = pos_next;
            count_d = count_q - brb_pkg::CNT_W'(1);
            if ((mark_i != '0) && (count_d < mark_i)) begin
              hw_d = 1'b0;
            end
          end
          res_d.fill      = count_d;
          res_d.highwater = hw_d;
          if (remain_q == brb_pkg::REQ_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (load) begin
      out_valid_d = 1'b1;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[head_q] <= cmd_i.data;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      pos_q       <= '0;
      count_q     <= '0;
      hw_q        <= 1'b0;
      remain_q    <= '0;
      is_read_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      pos_q       <= pos_d;
      count_q     <= count_d;
      hw_q        <= hw_d;
      remain_q    <= remain_d;
      is_read_q   <= is_read_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

`ifndef ASSERT_OFF
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= brb_pkg::CAP_CNT)
    else $error("fill level above capacity");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (brb_pkg::CNT_W'(head_q - tail_q) == count_q) ||
    ((head_q == tail_q) && (count_q == brb_pkg::CAP_CNT)) ||
    ((head_q >= tail_q) && (brb_pkg::CNT_W'(head_q - tail_q) == count_q)) ||
    ((head_q < tail_q) &&
     (brb_pkg::CNT_W'(head_q) + brb_pkg::CAP_CNT - brb_pkg::CNT_W'(tail_q) == count_q)))
    else $error("head and tail disagree with fill level");
  a_stream_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STREAM) |-> (remain_q != '0))
    else $error("byte run with nothing left to send");
  a_byte_not_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.byte_valid) |-> !out_q.accepted)
    else $error("byte result marked as stored write");
  a_run_peek_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_STREAM) && !is_read_q) |=> (count_q == $past(count_q)))
    else $error("peek changed the fill level");
`endif

endmodule

/* design/byte_ring_buffer_fifo.sv */
// Top level of the circular byte FIFO with high-water flag.
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tuser kind, tdata data_in + request_count
//  m_axis    out  m_axis_tvalid / m_axis_tready  tuser byte_valid, tlast last, tdata rest
//  cfg       in   cfg_valid_i / cfg_ready_o      cfg_data_i: high-water mark
//
// Write, skip, flush and status items give one result each, one item per cycle while the
// result output is not stalled. A read or peek fetches its first byte from the byte store,
// then sends one byte per cycle out of its registered read port unless the output stalls.
// A two-entry command queue sits between the input decode and the store logic, and
// a result register holds the output, so either side can stall without the other.
// Reset clears pointers, fill level, flag and mark; the byte store is not cleared.
module byte_ring_buffer_fifo (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] data_in, [14:8] request_count, [15] zero
  input  logic [2:0]  s_axis_tuser,   // [2:0] kind
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] data_out, [8] accepted, [19:9] level,
                                      // [20] highwater, [23:21] zero
  output logic [0:0]  m_axis_tuser,   // [0] byte_valid
  output logic        m_axis_tlast,   // last result of this item
  // high-water mark register
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [10:0] cfg_data_i
);

  logic                        cmd_valid;
  brb_pkg::cmd_t               cmd;
  logic                        cmd_pop;
  logic [brb_pkg::CNT_W-1:0]   mark_q;
  brb_pkg::res_t               res;

  // Mark register; writes must arrive only while the FIFO is quiet; the block does not enforce this.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_q <= '0;
    end else if (cfg_valid_i) begin
      mark_q <= cfg_data_i;
    end
  end

  brb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .kind_i      (s_axis_tuser),
    .data_i      (s_axis_tdata[7:0]),
    .req_i       (s_axis_tdata[14:8]),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  brb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .mark_i      (mark_q),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  // Result packing, lowest field first.
  assign m_axis_tdata = {3'b000, res.highwater, res.fill, res.accepted, res.data};
  assign m_axis_tuser = res.byte_valid;
  assign m_axis_tlast = res.last;

endmodule

/* dv/byte_ring_buffer_fifo_test.sv */
// Self-checking testbench for the circular byte FIFO with high-water flag.
module byte_ring_buffer_fifo_test;
  timeunit 1ns;
  timeprecision 1ps;

  // kinds past flush change nothing and answer with one status item
  localparam logic [brb_pkg::KIND_W-1:0] KIND_UNUSED_LO = 3'd5;
  localparam logic [brb_pkg::KIND_W-1:0] KIND_UNUSED_HI = 3'd7;
  localparam int unsigned                TAIL_CYCLES    = 50;

  // one row of the directed table: either a mark write or one input item
  typedef struct packed {
    logic                       is_mark;
    logic [brb_pkg::CNT_W-1:0]  mark;
    logic [brb_pkg::KIND_W-1:0] kind;
    logic [brb_pkg::BYTE_W-1:0] din;
    logic [brb_pkg::REQ_W-1:0]  req;
    logic                       typed;   // want holds a hand-written expectation
    brb_pkg::res_t              want;
  } step_row_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;  // [7:0] data_in, [14:8] request_count, [15] zero
  logic [2:0]  s_axis_tuser  = '0;  // [2:0] kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // [7:0] data_out, [8] accepted, [19:9] level,
                                    // [20] highwater, [23:21] zero
  logic [0:0]  m_axis_tuser;        // [0] byte_valid
  logic        m_axis_tlast;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [10:0] cfg_data_i    = '0;

  // side band for the monitor: hand-written expectation of the item on the bus
  logic          item_typed = 1'b0;
  brb_pkg::res_t item_want  = '0;

  // percent of cycles each side holds off
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  int error_count   = 0;
  int n_items       = 0;
  int n_results     = 0;
  int n_mark_writes = 0;
  int n_full_seen   = 0;
  int n_flag_seen   = 0;

  // predictor state
  logic [brb_pkg::BYTE_W-1:0] ring_bytes [0:brb_pkg::CAPACITY-1];
  logic [brb_pkg::ADDR_W-1:0] ring_head  = '0;
  logic [brb_pkg::ADDR_W-1:0] ring_tail  = '0;
  logic [brb_pkg::CNT_W-1:0]  ring_count = '0;
  logic                       ring_flag  = 1'b0;
  logic [brb_pkg::CNT_W-1:0]  ring_mark  = '0;

  brb_pkg::res_t fifo_results_due [$];

  byte_ring_buffer_fifo u_dut (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // receiver back-pressure
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  function automatic brb_pkg::res_t make_res(input logic [brb_pkg::BYTE_W-1:0] data,
                                             input logic bv, input logic lst,
                                             input logic acc,
                                             input logic [brb_pkg::CNT_W-1:0] fill,
                                             input logic hw);
    brb_pkg::res_t r;
    r.data       = data;
    r.byte_valid = bv;
    r.last       = lst;
    r.accepted   = acc;
    r.fill       = fill;
    r.highwater  = hw;
    return r;
  endfunction

  // single status item: no byte, last set
  function automatic brb_pkg::res_t status_res(input logic acc,
                                               input logic [brb_pkg::CNT_W-1:0] fill,
                                               input logic hw);
    return make_res('0, 1'b0, 1'b1, acc, fill, hw);
  endfunction

  function automatic logic [brb_pkg::ADDR_W-1:0] ring_advance(
      input logic [brb_pkg::ADDR_W-1:0] idx);
    return (idx == brb_pkg::ADDR_W'(brb_pkg::CAPACITY - 1)) ? '0
                                                             : idx + brb_pkg::ADDR_W'(1);
  endfunction

  task automatic drop_flag_below_mark();
    if (ring_mark != '0 && ring_count < ring_mark) ring_flag = 1'b0;
  endtask

  // Work out every result item one input item causes and queue them.
  task automatic predict_fifo_results(input logic [brb_pkg::KIND_W-1:0] kind,
                                      input logic [brb_pkg::BYTE_W-1:0] din,
                                      input logic [brb_pkg::REQ_W-1:0] req);
    logic [brb_pkg::CNT_W-1:0]  n;
    logic [brb_pkg::ADDR_W-1:0] pos;
    logic                       acc;
    int                         i;
    acc = 1'b0;
    n   = brb_pkg::CNT_W'(req);
    if (n > ring_count) n = ring_count;
    if (n > brb_pkg::CNT_W'(brb_pkg::MAX_BURST)) n = brb_pkg::CNT_W'(brb_pkg::MAX_BURST);
    if (kind == brb_pkg::KIND_CODE_WRITE) begin
      if (ring_count < brb_pkg::CAP_CNT) begin
        ring_bytes[ring_head] = din;
        ring_head  = ring_advance(ring_head);
        ring_count = ring_count + brb_pkg::CNT_W'(1);
        acc        = 1'b1;
      end
      // the flag can set even on a dropped byte
      if (ring_mark != '0 && ring_count >= ring_mark) ring_flag = 1'b1;
      fifo_results_due.push_back(status_res(acc, ring_count, ring_flag));
    end else if (kind == brb_pkg::KIND_CODE_FLUSH) begin
      ring_head  = '0;
      ring_tail  = '0;
      ring_count = '0;
      ring_flag  = 1'b0;
      fifo_results_due.push_back(status_res(1'b0, ring_count, ring_flag));
    end else if (kind == brb_pkg::KIND_CODE_SKIP) begin
      for (i = 0; i < int'(n); i++) begin
        ring_tail  = ring_advance(ring_tail);
        ring_count = ring_count - brb_pkg::CNT_W'(1);
        drop_flag_below_mark();
      end
      drop_flag_below_mark();
      fifo_results_due.push_back(status_res(1'b0, ring_count, ring_flag));
    end else if (kind == brb_pkg::KIND_CODE_READ || kind == brb_pkg::KIND_CODE_PEEK) begin
      if (n == '0) begin
        if (kind == brb_pkg::KIND_CODE_READ) drop_flag_below_mark();
        fifo_results_due.push_back(status_res(1'b0, ring_count, ring_flag));
      end else begin
        pos = ring_tail;
        for (i = 0; i < int'(n); i++) begin
          logic [brb_pkg::BYTE_W-1:0] b;
          b   = ring_bytes[pos];
          pos = ring_advance(pos);
          if (kind == brb_pkg::KIND_CODE_READ) begin
            ring_tail  = pos;
            ring_count = ring_count - brb_pkg::CNT_W'(1);
            drop_flag_below_mark();
          end
          fifo_results_due.push_back(make_res(b, 1'b1, (i + 1 == int'(n)), 1'b0,
                                              ring_count, ring_flag));
        end
      end
    end else begin
      fifo_results_due.push_back(status_res(1'b0, ring_count, ring_flag));
    end
  endtask

  task automatic report_mismatch(input string field, input int want, input int got);
    $display("%0t: mismatch in %s: expected %0d, actual %0d", $time, field, want, got);
    error_count++;
  endtask

  // Monitor: checks result items, tracks mark writes, predicts on accepted items.
  // All sampling happens at the edge, before any NBA of this step lands.
  always @(posedge clk_i) begin
    brb_pkg::res_t got;
    brb_pkg::res_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = make_res(m_axis_tdata[7:0], m_axis_tuser[0], m_axis_tlast, m_axis_tdata[8],
                       m_axis_tdata[19:9], m_axis_tdata[20]);
        n_results++;
        if (got.fill == brb_pkg::CAP_CNT) n_full_seen++;
        if (got.highwater) n_flag_seen++;
        if (fifo_results_due.size() == 0) begin
          $display("%0t: result item with nothing expected, tdata %h tuser %b tlast %b",
                   $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
          error_count++;
        end else begin
          want = fifo_results_due.pop_front();
          if (got.data !== want.data)
            report_mismatch("data_out", int'(want.data), int'(got.data));
          if (got.byte_valid !== want.byte_valid)
            report_mismatch("byte_valid", int'(want.byte_valid), int'(got.byte_valid));
          if (got.last !== want.last)
            report_mismatch("last", int'(want.last), int'(got.last));
          if (got.accepted !== want.accepted)
            report_mismatch("accepted", int'(want.accepted), int'(got.accepted));
          if (got.fill !== want.fill)
            report_mismatch("level", int'(want.fill), int'(got.fill));
          if (got.highwater !== want.highwater)
            report_mismatch("highwater", int'(want.highwater), int'(got.highwater));
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        ring_mark = cfg_data_i;
        n_mark_writes++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        n_items++;
        predict_fifo_results(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[14:8]);
        // hand-written rows replace the single predicted status item
        if (item_typed) begin
          void'(fifo_results_due.pop_back());
          fifo_results_due.push_back(item_want);
        end
      end
    end
  end

  // Offer one item, with random hold-off first; returns at the accepting edge.
  task automatic send_item(input logic [brb_pkg::KIND_W-1:0] kind,
                           input logic [brb_pkg::BYTE_W-1:0] din,
                           input logic [brb_pkg::REQ_W-1:0] req, input logic typed,
                           input brb_pkg::res_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {1'b0, req, din};
    item_typed    <= typed;
    item_want     <= want;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Sender pauses until every expected result item has arrived.
  task automatic wait_results_done();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (fifo_results_due.size() != 0);
  endtask

  // Mark is only written while the block is idle.
  task automatic write_mark(input logic [brb_pkg::CNT_W-1:0] value);
    wait_results_done();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic step_row_t row_item(input logic [brb_pkg::KIND_W-1:0] kind,
                                         input logic [brb_pkg::BYTE_W-1:0] din,
                                         input logic [brb_pkg::REQ_W-1:0] req,
                                         input logic typed, input brb_pkg::res_t want);
    step_row_t r;
    r         = '0;
    r.kind    = kind;
    r.din     = din;
    r.req     = req;
    r.typed   = typed;
    r.want    = want;
    return r;
  endfunction

  function automatic step_row_t row_mark(input logic [brb_pkg::CNT_W-1:0] value);
    step_row_t r;
    r         = '0;
    r.is_mark = 1'b1;
    r.mark    = value;
    return r;
  endfunction

  // Directed table: empty-buffer requests, clamps, unused kinds, flag set and clear, flush.
  task automatic run_directed();
    step_row_t     rows [$];
    brb_pkg::res_t none;
    none = '0;
    rows.push_back(row_item(brb_pkg::KIND_CODE_READ,  8'h00, 7'd0,   1'b1,
                            status_res(1'b0, 11'd0, 1'b0)));
    rows.push_back(row_item(brb_pkg::KIND_CODE_PEEK,  8'hFF, 7'd127, 1'b1,
                            status_res(1'b0, 11'd0, 1'b0)));
    rows.push_back(row_item(brb_pkg::KIND_CODE_SKIP,  8'h00, 7'd1,   1'b1,
                            status_res(1'b0, 11'd0, 1'b0)));
    rows.push_back(row_item(brb_pkg::KIND_CODE_WRITE, 8'h00, 7'd0,   1'b1,
                            status_res(1'b1, 11'd1, 1'b0)));
    rows.push_back(row_item(brb_pkg::KIND_CODE_WRITE, 8'hFF, 7'd127, 1'b1,
                            status_res(1'b1, 11'd2, 1'b0)));
    rows.push_back(row_item(brb_pkg::KIND_CODE_WRITE, 8'hA5, 7'd64,  1'b1,
                            status_res(1'b1, 11'd3, 1'b0)));
    rows.push_back(row_item(brb_pkg::KIND_CODE_PEEK,  8'h00, 7'd127, 1'b0, none));
    rows.push_back(row_item(brb_pkg::KIND_CODE_READ,  8'h00, 7'd1,   1'b0, none));
    rows.push_back(row_item(KIND_UNUSED_LO,           8'hFF, 7'd127, 1'b1,
                            status_res(1'b0, 11'd2, 1'b0)));
    rows.push_back(row_item(KIND_UNUSED_HI,           8'h5A, 7'd3,   1'b1,
                            status_res(1'b0, 11'd2, 1'b0)));
    rows.push_back(row_item(brb_pkg::KIND_CODE_SKIP,  8'h00, 7'd127, 1'b1,
                            status_res(1'b0, 11'd0, 1'b0)));
    rows.push_back(row_item(brb_pkg::KIND_CODE_FLUSH, 8'h00, 7'd0,   1'b1,
                            status_res(1'b0, 11'd0, 1'b0)));
    rows.push_back(row_mark(11'd2));
    rows.push_back(row_item(brb_pkg::KIND_CODE_WRITE, 8'h11, 7'd0,   1'b1,
                            status_res(1'b1, 11'd1, 1'b0)));
    rows.push_back(row_item(brb_pkg::KIND_CODE_WRITE, 8'h22, 7'd0,   1'b1,
                            status_res(1'b1, 11'd2, 1'b1)));
    rows.push_back(row_item(brb_pkg::KIND_CODE_READ,  8'h00, 7'd0,   1'b1,
                            status_res(1'b0, 11'd2, 1'b1)));
    rows.push_back(row_item(brb_pkg::KIND_CODE_READ,  8'h00, 7'd1,   1'b0, none));
    rows.push_back(row_item(brb_pkg::KIND_CODE_WRITE, 8'h33, 7'd0,   1'b1,
                            status_res(1'b1, 11'd2, 1'b1)));
    rows.push_back(row_item(brb_pkg::KIND_CODE_PEEK,  8'h00, 7'd2,   1'b0, none));
    rows.push_back(row_item(brb_pkg::KIND_CODE_SKIP,  8'h00, 7'd1,   1'b1,
                            status_res(1'b0, 11'd1, 1'b0)));
    rows.push_back(row_item(brb_pkg::KIND_CODE_WRITE, 8'h44, 7'd0,   1'b1,
                            status_res(1'b1, 11'd2, 1'b1)));
    rows.push_back(row_item(brb_pkg::KIND_CODE_FLUSH, 8'hFF, 7'd127, 1'b1,
                            status_res(1'b0, 11'd0, 1'b0)));
    rows.push_back(row_mark(11'd0));
    foreach (rows[i]) begin
      if (rows[i].is_mark) write_mark(rows[i].mark);
      else send_item(rows[i].kind, rows[i].din, rows[i].req, rows[i].typed, rows[i].want);
    end
  endtask

  // Mostly runs of writes followed by reads, peeks and skips; some flushes and unused kinds.
  task automatic run_mixed(input int n_target);
    int                        sent;
    int                        pick;
    int                        run_len;
    logic [brb_pkg::REQ_W-1:0] req;
    sent = 0;
    while (sent < n_target) begin
      pick = $urandom_range(0, 99);
      req  = ($urandom_range(0, 7) == 0) ? brb_pkg::REQ_W'($urandom_range(0, 127))
                                         : brb_pkg::REQ_W'($urandom_range(0, 40));
      if (pick < 50) begin
        run_len = $urandom_range(1, 24);
        repeat (run_len) send_item(brb_pkg::KIND_CODE_WRITE, brb_pkg::BYTE_W'($urandom),
                                   brb_pkg::REQ_W'($urandom), 1'b0, '0);
        sent += run_len;
      end else if (pick < 70) begin
        send_item(brb_pkg::KIND_CODE_READ, brb_pkg::BYTE_W'($urandom), req, 1'b0, '0);
        sent++;
      end else if (pick < 80) begin
        send_item(brb_pkg::KIND_CODE_PEEK, brb_pkg::BYTE_W'($urandom), req, 1'b0, '0);
        sent++;
      end else if (pick < 90) begin
        send_item(brb_pkg::KIND_CODE_SKIP, brb_pkg::BYTE_W'($urandom), req, 1'b0, '0);
        sent++;
      end else if (pick < 95) begin
        send_item(brb_pkg::KIND_CODE_FLUSH, brb_pkg::BYTE_W'($urandom),
                  brb_pkg::REQ_W'($urandom), 1'b0, '0);
        sent++;
      end else begin
        // changes nothing in the block, so not counted
        send_item(brb_pkg::KIND_W'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI)),
                  brb_pkg::BYTE_W'($urandom), brb_pkg::REQ_W'($urandom), 1'b0, '0);
      end
    end
  endtask

  // Fill past capacity (drops, flag at full), full bursts, then drain with skips so
  // both pointers wrap.
  task automatic run_fill();
    repeat (brb_pkg::CAPACITY + 6)
      send_item(brb_pkg::KIND_CODE_WRITE, brb_pkg::BYTE_W'($urandom),
                brb_pkg::REQ_W'($urandom), 1'b0, '0);
    send_item(brb_pkg::KIND_CODE_PEEK, brb_pkg::BYTE_W'($urandom), 7'd127, 1'b0, '0);
    send_item(brb_pkg::KIND_CODE_READ, brb_pkg::BYTE_W'($urandom), 7'd64, 1'b0, '0);
    send_item(brb_pkg::KIND_CODE_READ, brb_pkg::BYTE_W'($urandom), 7'd100, 1'b0, '0);
    repeat (16) send_item(brb_pkg::KIND_CODE_SKIP, brb_pkg::BYTE_W'($urandom),
                          brb_pkg::REQ_W'($urandom_range(64, 127)), 1'b0, '0);
    repeat (40) send_item(brb_pkg::KIND_CODE_WRITE, brb_pkg::BYTE_W'($urandom),
                          brb_pkg::REQ_W'($urandom), 1'b0, '0);
    send_item(brb_pkg::KIND_CODE_READ, brb_pkg::BYTE_W'($urandom), 7'd127, 1'b0, '0);
    send_item(brb_pkg::KIND_CODE_PEEK, brb_pkg::BYTE_W'($urandom), 7'd127, 1'b0, '0);
  endtask

  // Main sequence
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sender idles less than the receiver
    send_idle_pct = 33;
    recv_idle_pct = 69;
    run_directed();
    write_mark(brb_pkg::CNT_W'($urandom_range(1, 48)));
    run_mixed(90);
    write_mark(11'd0);
    run_mixed(80);

    // receiver idles less than the sender; a mark that cannot be reached, then a random mark
    send_idle_pct = 69;
    recv_idle_pct = 33;
    write_mark(11'd2047);
    run_mixed(70);
    write_mark(brb_pkg::CNT_W'($urandom_range(0, 2047)));
    run_mixed(70);

    // full rate both ways
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_mark(brb_pkg::CAP_CNT);
    run_fill();
    write_mark(11'd1);
    run_mixed(80);
    write_mark(brb_pkg::CNT_W'($urandom_range(1, 48)));
    run_mixed(80);

    wait_results_done();
    // catch any stray result items
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Run covered %0d input items, %0d result items, %0d mark writes.",
             n_items, n_results, n_mark_writes);
    $display("Results seen at full level: %0d, with high-water flag set: %0d.",
             n_full_seen, n_flag_seen);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #100_000_000;
    $display("%0t: timeout, %0d result items still expected", $time,
             fifo_results_due.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule

/* sim.f */
design/brb_pkg.sv
design/brb_front.sv
design/brb_back.sv
design/byte_ring_buffer_fifo.sv
dv/byte_ring_buffer_fifo_test.sv
